// ----- rtl/sobol_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sobol_pkg;
    localparam int MAX_DIMS_DEF   = 16;
    localparam int FRAC_BITS_DEF  = 32;
    localparam int MAX_DEGREE_DEF = 18;
    localparam int OUT_W          = 32;
    localparam int CFG_W          = 32;

    typedef enum logic [1:0] {
        OP_SET_POLY = 2'd0,
        OP_WRITE_M  = 2'd1,
        OP_RESTART  = 2'd2,
        OP_NEXT     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_DONE     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/sobol_sequence_generator.sv -----
// Channel | Direction | Handshake               | Payload
// in      | input     | i_valid / o_stall       | opcode, dim_select, degree, poly_bits,
//         |           |                         | term_index, init_value
// out     | output    | o_valid / i_stall       | coordinate, dim_out, last, status
// cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One item at a time; the input stalls while an item is at work. Set polynomial and
// write m complete when accepted. Next point reads the table and updates every
// dimension in turn (S_NEXT_RD, S_NEXT_UPD), emitting each of the first dims
// coordinates through S_OUT; an error result goes out through S_ERR. Restart derives
// each dimension's terms (S_EXP_RD, S_EXP_ACC, S_EXP_WR), then seeds it from the Gray
// code of start-1 (S_SEED_RD, S_SEED_ACC). Reset is synchronous active low; the direction
// table has no reset. A stalled output register holds the engine.
`timescale 1ns / 1ps
`default_nettype none
module sobol_sequence_generator
    import sobol_pkg::*;
#(
    parameter int MAX_DIMS   = MAX_DIMS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_dim_select,
    input  wire logic [4:0]  i_degree,
    input  wire logic [16:0] i_poly_bits,
    input  wire logic [4:0]  i_term_index,
    input  wire logic [17:0] i_init_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_coordinate,
    output logic [3:0]       o_dim_out,
    output logic             o_last,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int JW    = $clog2(FRAC_BITS);
    localparam int DEPTH = MAX_DIMS * FRAC_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(MAX_DEGREE + 1);
    localparam int NW    = $clog2(MAX_DIMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXP_RD, S_EXP_ACC, S_EXP_WR, S_SEED_RD, S_SEED_ACC,
        S_NEXT_RD, S_NEXT_UPD, S_OUT, S_ERR
    } t_state;

    logic [FRAC_BITS-1:0] r_mem [DEPTH];
    logic [FRAC_BITS-1:0] r_rdata;

    logic [FRAC_BITS-1:0] r_coord [MAX_DIMS];
    logic [QW-1:0]        r_deg   [MAX_DIMS];
    logic [16:0]          r_poly  [MAX_DIMS];

    t_state       r_state;
    logic [NW-1:0] r_dims;
    logic [31:0]  r_start, r_count, r_index, r_left;
    logic         r_started;
    logic [DW-1:0] r_d;
    logic [JW:0]  r_j;
    logic [JW:0]  r_k;
    logic [FRAC_BITS-1:0] r_acc;
    logic         r_ovalid;
    logic [31:0]  r_ocoord;
    logic [3:0]   r_odim;
    logic         r_olast;
    logic [1:0]   r_ostat;
    logic [31:0]  r_gray;

    logic [QW-1:0] w_q;
    logic [16:0]   w_p;
    logic [31:0]   w_prev;
    logic [5:0]    w_tz;
    logic          w_zero;
    logic          w_in_acc;
    logic          w_out_load;
    logic [AW-1:0] w_raddr;

    assign w_q      = r_deg[r_d];
    assign w_p      = r_poly[r_d];
    assign w_prev   = r_start - 32'd1;
    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && (r_state == S_IDLE);
    assign w_out_load = ((r_state == S_OUT) || (r_state == S_ERR)) && (!r_ovalid || !i_stall);
    assign o_valid  = r_ovalid;
    assign o_coordinate = r_ocoord;
    assign o_dim_out = r_odim;
    assign o_last   = r_olast;
    assign o_status = r_ostat;

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] d, input logic [JW:0] j);
        return AW'(d * FRAC_BITS) + AW'(j[JW-1:0]);
    endfunction

    always_comb begin
        w_tz   = 6'd32;
        w_zero = 1'b1;
        for (int b = 31; b >= 0; b--) begin
            if (r_index[b]) begin
                w_tz   = 6'(b);
                w_zero = 1'b0;
            end
        end
    end

    // expansion term: k==0 means m[j-q] ^ (m[j-q]<<q); k>0 m[j-k]<<k when a_k
    logic [FRAC_BITS-1:0] w_term;
    always_comb begin
        w_term = '0;
        if (r_k == '0)
            w_term = r_rdata ^ (r_rdata << w_q);
        else if (w_p[QW'(w_q - QW'(r_k) - QW'(1))])
            w_term = r_rdata << r_k;
    end

    logic [FRAC_BITS-1:0] w_dword;
    assign w_dword = r_rdata << (JW'(FRAC_BITS - 1) - r_j[JW-1:0]);

    // read address for the state about to consume data next cycle
    always_comb begin
        case (r_state)
            S_EXP_RD:  w_raddr = f_addr(r_d, r_j - (JW + 1)'(w_q));
            S_EXP_ACC: w_raddr = f_addr(r_d, r_j - r_k - 1'b1);
            default:   w_raddr = f_addr(r_d, r_j);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dims    <= NW'(1);
            r_start   <= 32'd1;
            r_count   <= 32'd1;
            r_index   <= '0;
            r_left    <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_coord[i] <= '0;
                r_deg[i]   <= '0;
                r_poly[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DIMS: begin
                        if (i_cfg_data[4:0] == 5'd0) r_dims <= NW'(1);
                        else if (32'(i_cfg_data[4:0]) > MAX_DIMS) r_dims <= NW'(MAX_DIMS);
                        else r_dims <= NW'(i_cfg_data[4:0]);
                    end
                    REG_START: r_start <= i_cfg_data;
                    REG_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (t_opcode'(i_opcode))
                            OP_SET_POLY: begin
                                if (32'(i_dim_select) < MAX_DIMS) begin
                                    r_deg[DW'(i_dim_select)] <= (32'(i_degree) > MAX_DEGREE)
                                        ? QW'(MAX_DEGREE) : QW'(i_degree);
                                    r_poly[DW'(i_dim_select)] <= i_poly_bits;
                                end
                            end
                            OP_WRITE_M: begin
                                if (32'(i_dim_select) < MAX_DIMS && 32'(i_term_index) < MAX_DEGREE
                                    && 32'(i_term_index) < FRAC_BITS)
                                    r_mem[f_addr(DW'(i_dim_select), (JW + 1)'(i_term_index))]
                                        <= FRAC_BITS'(i_init_value);
                            end
                            OP_RESTART: begin
                                r_d     <= '0;
                                r_gray  <= w_prev ^ (w_prev >> 1);
                                r_index <= r_start;
                                r_left  <= r_count;
                                r_started <= 1'b1;
                                r_j     <= '0;
                                r_state <= S_EXP_RD;
                            end
                            OP_NEXT: begin
                                if (!r_started || r_left == '0 || w_zero || w_tz >= FRAC_BITS)
                                    r_state <= S_ERR;
                                else begin
                                    r_j     <= (JW + 1)'(w_tz);
                                    r_d     <= '0;
                                    r_state <= S_NEXT_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EXP_RD: begin
                    // per dimension: degree 0 fills ones, else j from q
                    if (w_q == '0) begin
                        r_mem[f_addr(r_d, r_j)] <= FRAC_BITS'(1);
                        if (r_j == (JW + 1)'(FRAC_BITS - 1)) begin
                            r_j <= '0; r_acc <= '0; r_state <= S_SEED_RD;
                        end else r_j <= r_j + 1'b1;
                    end else if (r_j < (JW + 1)'(w_q)) begin
                        r_j <= (JW + 1)'(w_q);
                    end else if (r_j >= (JW + 1)'(FRAC_BITS)) begin
                        r_j <= '0; r_acc <= '0; r_state <= S_SEED_RD;
                    end else begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_EXP_ACC;
                    end
                end
                S_EXP_ACC: begin
                    r_acc <= r_acc ^ w_term;
                    if (r_k + 1'b1 >= (JW + 1)'(w_q)) r_state <= S_EXP_WR;
                    else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_EXP_ACC;
                    end
                end
                S_EXP_WR: begin
                    r_mem[f_addr(r_d, r_j)] <= r_acc;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_EXP_RD;
                end
                S_SEED_RD: begin
                    if (r_j >= (JW + 1)'(FRAC_BITS) || r_j > (JW + 1)'(31)) begin
                        r_coord[r_d] <= r_acc;
                        r_j <= '0;
                        if (32'(r_d) == MAX_DIMS - 1) r_state <= S_IDLE;
                        else begin
                            r_d <= r_d + 1'b1; r_state <= S_EXP_RD;
                        end
                    end else if (!r_gray[5'(r_j)]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_SEED_ACC;
                    end
                end
                S_SEED_ACC: begin
                    r_acc   <= r_acc ^ w_dword;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SEED_RD;
                end
                S_NEXT_RD: begin
                    r_state <= S_NEXT_UPD;
                end
                S_NEXT_UPD: begin
                    r_coord[r_d] <= r_coord[r_d] ^ w_dword;
                    if (NW'(r_d) < r_dims) begin
                        r_acc   <= r_coord[r_d] ^ w_dword;
                        r_state <= S_OUT;
                    end else if (32'(r_d) == MAX_DIMS - 1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_d <= r_d + 1'b1; r_state <= S_NEXT_RD;
                    end
                    if (32'(r_d) == MAX_DIMS - 1) begin
                        r_index <= r_index + 32'd1;
                        r_left  <= r_left - 32'd1;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_ocoord <= 32'(r_acc);
                        r_odim   <= 4'(r_d);
                        r_olast  <= (NW'(r_d) + 1'b1 == r_dims);
                        r_ostat  <= ST_OK;
                        if (32'(r_d) == MAX_DIMS - 1) r_state <= S_IDLE;
                        else begin
                            r_d <= r_d + 1'b1; r_state <= S_NEXT_RD;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_load) begin
                        r_ocoord <= '0;
                        r_odim   <= '0;
                        r_olast  <= 1'b1;
                        r_ostat  <= !r_started ? ST_NOT_STARTED :
                                    (r_left == '0) ? ST_DONE : ST_OVERFLOW;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input open while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_coordinate)))
        else $error("output changed under stall");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last) else $error("error not last");
`endif
endmodule
`default_nettype wire
